>>> rtl/core/skn_pkg.sv
// Package for the sorted key node table: request and result item types,
// request and status codes, sequencer states and default sizes.
// Used by every module under rtl/core.
package skn_pkg;

    localparam int MAX_KEYS_DEF = 64;   // default node capacity
    localparam int KEY_BITS_DEF = 32;   // default stored key width
    localparam int KEY_FIELD_W  = 32;   // key field of a request item
    localparam int REC_W        = 32;   // page and slot width
    localparam int POS_W        = 7;    // position and entry_count fields

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [KEY_FIELD_W-1:0] key;
        logic [REC_W-1:0]       rec_page;
        logic [REC_W-1:0]       rec_slot;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entry_count;
        logic [REC_W-1:0] found_page;
        logic [REC_W-1:0] found_slot;
    } t_res;

    // Result of the shared key comparator.
    typedef struct packed {
        logic lt;   // stored key below search key
        logic eq;   // stored key equal to search key
    } t_cmp_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,     // issue read of bisection midpoint
        S_SCMP,     // compare midpoint, narrow the range
        S_HRD,      // issue read of lower-bound entry
        S_HCMP,     // check lower-bound entry for a hit
        S_EXEC,     // pick the action and the status
        S_UP_RD,    // insert shift: read entry below
        S_UP_WR,    // insert shift: write it one place up
        S_INS,      // insert: write the new entry
        S_DN_RD,    // remove shift: read entry above
        S_DN_WR,    // remove shift: write it one place down
        S_DONE      // hand the result to the output register
    } t_state;

endpackage

>>> rtl/core/skn_cmp.sv
// Shared key comparator of the sorted key node table.
// Depends on skn_pkg for the comparison result type.
module skn_cmp
    import skn_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic [KEY_BITS-1:0] i_a,
    input  logic [KEY_BITS-1:0] i_b,
    input  logic                i_signed,
    output t_cmp_res            o_res
);

    logic [KEY_BITS-1:0] w_flip;
    logic [KEY_BITS-1:0] w_a;
    logic [KEY_BITS-1:0] w_b;

    // Flip the sign bit so that a signed order becomes an unsigned one.
    assign w_flip  = {i_signed, {(KEY_BITS-1){1'b0}}};
    assign w_a     = i_a ^ w_flip;
    assign w_b     = i_b ^ w_flip;
    assign o_res.lt = (w_a < w_b);
    assign o_res.eq = (w_a == w_b);

endmodule

>>> rtl/core/skn_store.sv
// Entry memory of the sorted key node table: one write port, one read port,
// registered read data. Depends on skn_pkg for default sizes.
module skn_store
    import skn_pkg::*;
#(
    parameter int DEPTH  = MAX_KEYS_DEF,
    parameter int ADDR_W = $clog2(MAX_KEYS_DEF),
    parameter int DATA_W = KEY_BITS_DEF + 2 * REC_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/core/sorted_key_node_table.sv
// Sequence: bisection steps of a read and a compare each (at most clog2(MAX_KEYS+1)), the end
//   of the search, the hit check read and compare, the action pick, a read and a write per entry
//   shifted, the insert write and the hand-off. Uses skn_pkg, skn_cmp and skn_store.
// Throughput: one item at a time; o_in_ready is high only in idle, entered in the cycle after the
//   hand-off, which waits while the output register holds an unaccepted result.
// Reset: clears the count and the output valid flag, sets compare_signed; no memory clear.
module sorted_key_node_table
    import skn_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_res        o_out,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int DATA_W = KEY_BITS + 2 * REC_W;

    t_state r_state, n_state;

    // latched request item
    logic [1:0]          r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [REC_W-1:0]    r_page;
    logic [REC_W-1:0]    r_slot;

    // bisection range; r_lo ends as the lower-bound position
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_mid;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_count;
    logic                r_hit;
    logic [1:0]          r_status;
    logic [REC_W-1:0]    r_fpage;
    logic [REC_W-1:0]    r_fslot;
    logic                r_cmp_signed;
    logic                r_out_valid;
    t_res                r_out;

    logic [CNT_W:0]      w_sum;
    logic [CNT_W-1:0]    w_mid;
    logic [CNT_W-1:0]    w_idx_dn;
    logic [CNT_W-1:0]    w_idx_up;
    logic                w_accept;
    logic                w_cfg_wr;
    logic                w_ins_ok;
    logic                w_rem_ok;
    logic                w_lookup;
    logic                w_load_out;
    logic                w_more_dn;

    // memory port
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [DATA_W-1:0]   w_wdata;
    logic                w_re;
    logic [IDX_W-1:0]    w_raddr;
    logic [DATA_W-1:0]   w_rdata;
    logic [KEY_BITS-1:0] w_rkey;
    t_cmp_res            w_cmp;

    // ------------------------------------------------------------------
    // Configuration: one register, compare_signed, at byte address 0.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, r_cmp_signed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_signed <= 1'b1;
        end else if (w_cfg_wr && paddr[2] == 1'b0) begin
            r_cmp_signed <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Shared units: entry memory and the key comparator.
    // ------------------------------------------------------------------
    skn_store #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Entry layout: key on top, then page, then slot.
    assign w_rkey = w_rdata[DATA_W-1 -: KEY_BITS];

    skn_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_a      (w_rkey),
        .i_b      (r_key),
        .i_signed (r_cmp_signed),
        .o_res    (w_cmp)
    );

    // ------------------------------------------------------------------
    // Decode helpers.
    // ------------------------------------------------------------------
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CNT_W:1];
    assign w_idx_dn   = r_idx - CNT_W'(1);
    assign w_idx_up   = r_idx + CNT_W'(1);
    // Code 3 is unused and runs as a lookup.
    assign w_lookup   = (r_req != REQ_INSERT) && (r_req != REQ_REMOVE);
    assign w_ins_ok   = (r_req == REQ_INSERT) && !r_hit && (r_count < CNT_W'(MAX_KEYS));
    assign w_rem_ok   = (r_req == REQ_REMOVE) && r_hit;
    // In DN_WR the count is already decremented; continue while idx+1 < count.
    assign w_more_dn  = (w_idx_up < r_count);
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SRCH;
            end
            S_SRCH: begin
                n_state = (r_lo < r_hi) ? S_SCMP : S_HRD;
            end
            S_SCMP: n_state = S_SRCH;
            S_HRD: begin
                n_state = (r_lo < r_count) ? S_HCMP : S_EXEC;
            end
            S_HCMP: n_state = S_EXEC;
            S_EXEC: begin
                priority if (w_ins_ok) begin
                    n_state = (r_count > r_lo) ? S_UP_RD : S_INS;
                end else if (w_rem_ok) begin
                    n_state = ({1'b0, r_lo} + (CNT_W+1)'(1) < {1'b0, r_count}) ?
                              S_DN_RD : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP_RD: n_state = S_UP_WR;
            S_UP_WR: n_state = (w_idx_dn > r_lo) ? S_UP_RD : S_INS;
            S_INS:   n_state = S_DONE;
            S_DN_RD: n_state = S_DN_WR;
            S_DN_WR: n_state = w_more_dn ? S_DN_RD : S_DONE;
            S_DONE: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: memory port and handshake outputs.
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = w_rdata;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_SRCH: begin
                w_re    = (r_lo < r_hi);
                w_raddr = IDX_W'(w_mid);
            end
            S_HRD: begin
                w_re    = (r_lo < r_count);
                w_raddr = IDX_W'(r_lo);
            end
            S_UP_RD: begin
                w_re    = 1'b1;
                w_raddr = IDX_W'(w_idx_dn);
            end
            S_UP_WR: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_idx);
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_lo);
                w_wdata = {r_key, r_page, r_slot};
            end
            S_DN_RD: begin
                w_re    = 1'b1;
                w_raddr = IDX_W'(w_idx_up);
            end
            S_DN_WR: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_idx);
            end
            S_SCMP, S_HCMP, S_EXEC, S_DONE: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Insert and remove commit the new count as soon as the action is chosen.
            if (r_state == S_EXEC && w_ins_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (r_state == S_EXEC && w_rem_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // Latch the item and open the bisection over all held entries.
                r_req  <= i_in.req_type;
                r_key  <= KEY_BITS'(i_in.key);
                r_page <= i_in.rec_page;
                r_slot <= i_in.rec_slot;
                r_lo   <= '0;
                r_hi   <= r_count;
            end
            S_SRCH: r_mid <= w_mid;
            S_SCMP: begin
                if (w_cmp.lt) begin
                    r_lo <= r_mid + CNT_W'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            S_HRD: r_hit <= 1'b0;
            S_HCMP: begin
                r_hit   <= w_cmp.eq;
                r_fpage <= w_rdata[2*REC_W-1:REC_W];
                r_fslot <= w_rdata[REC_W-1:0];
            end
            S_EXEC: begin
                priority if (r_req == REQ_INSERT) begin
                    if (r_hit) begin
                        r_status <= ST_DUP;
                    end else if (!w_ins_ok) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_DONE;
                    end
                end else begin
                    r_status <= r_hit ? ST_DONE : ST_ABSENT;
                end
                // Insert shifts from the old top down; remove from the hit upward.
                r_idx <= w_ins_ok ? r_count : r_lo;
            end
            S_UP_WR: r_idx <= w_idx_dn;
            S_DN_WR: r_idx <= w_idx_up;
            S_UP_RD, S_INS, S_DN_RD, S_DONE: ;
            default: ;
        endcase
    end

    // Output register parts the result side from the sequencer.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.status      <= r_status;
            r_out.position    <= POS_W'(r_lo);
            r_out.entry_count <= POS_W'(r_count);
            if (w_lookup && r_hit) begin
                r_out.found_page <= r_fpage;
                r_out.found_slot <= r_fslot;
            end else begin
                r_out.found_page <= '0;
                r_out.found_slot <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("entry count above capacity");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("bisection range out of order");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SRCH))
        else $error("accepted item did not start a search");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_status == ST_FULL) |-> (r_count == CNT_W'(MAX_KEYS)))
        else $error("full status with room left");

endmodule
